### hw/rtl/btpl_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the trie lookup unit.
`default_nettype none

package btpl_pkg;

  // Default node pool size, a top-level parameter
  localparam int unsigned NODE_COUNT = 65536;

  // Fixed by the request and response field widths
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned PORT_COUNT = 4;
  localparam int unsigned HOP_W      = 32;
  localparam int unsigned PORT_W     = 2;
  localparam int unsigned LVL_W      = $clog2(KEY_BITS + 1);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    RSP_INSERTED  = 2'd0,
    RSP_FOUND     = 2'd1,
    RSP_NO_ROUTE  = 2'd2,
    RSP_POOL_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_ROUTE,
    S_DONE
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic init_root;    // write the empty root entry
    logic accept;       // latch the request, read the root
    logic step;         // descend to the existing child, read it
    logic observe;      // lookup: keep the route of the node just read
    logic link;         // write the parent's child pointer to the next free node
    logic alloc;        // initialize the next free node and descend into it
    logic write_route;  // store hop and port at the current node
    logic set_full;     // mark the insert as failed on an empty pool
    logic finish;       // load the response register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic at_end;       // walk limit reached (depth for lookup, mask end for insert)
    logic child_null;   // chosen child pointer is null
    logic pool_full;    // no node left to allocate now
    logic chain_cont;   // insert goes on past the node being allocated
    logic chain_ok;     // a further node is still available
    logic out_free;     // response register can take a new result
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/btpl_if.sv
// Request and response channel interfaces of the trie lookup unit.
`default_nettype none

interface btpl_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] key;
  logic [31:0] prefix_mask;
  logic [31:0] hop_address;
  logic [1:0]  port_in;

  modport source (output valid, req_type, key, prefix_mask, hop_address, port_in,
                  input ready);
  modport sink   (input valid, req_type, key, prefix_mask, hop_address, port_in,
                  output ready);
endinterface

interface btpl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] hop_out;
  logic [1:0]  port_out;

  modport source (output valid, status, hop_out, port_out, input ready);
  modport sink   (input valid, status, hop_out, port_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/btpl_ctrl.sv
// Controller state machine sequencing the trie walk, allocation and route write.
`default_nettype none

module btpl_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire btpl_pkg::stat_t stat_i,
  output btpl_pkg::cmd_t       cmd_o
);

  btpl_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btpl_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      btpl_pkg::S_INIT: begin
        cmd_o.init_root = 1'b1;
        state_d         = btpl_pkg::S_IDLE;
      end
      btpl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = btpl_pkg::S_WALK;
        end
      end
      btpl_pkg::S_WALK: begin
        if (stat_i.is_lookup) begin
          cmd_o.observe = 1'b1;
          if (stat_i.at_end || stat_i.child_null) begin
            state_d = btpl_pkg::S_DONE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end else if (stat_i.at_end) begin
          state_d = btpl_pkg::S_ROUTE;
        end else if (!stat_i.child_null) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.pool_full) begin
          cmd_o.set_full = 1'b1;
          state_d        = btpl_pkg::S_DONE;
        end else begin
          cmd_o.link = 1'b1;
          state_d    = btpl_pkg::S_ALLOC;
        end
      end
      btpl_pkg::S_ALLOC: begin
        // every node below a fresh node is fresh too: one node per cycle
        cmd_o.alloc = 1'b1;
        if (!stat_i.chain_cont) begin
          state_d = btpl_pkg::S_ROUTE;
        end else if (!stat_i.chain_ok) begin
          cmd_o.set_full = 1'b1;
          state_d        = btpl_pkg::S_DONE;
        end
      end
      btpl_pkg::S_ROUTE: begin
        cmd_o.write_route = 1'b1;
        state_d           = btpl_pkg::S_DONE;
      end
      btpl_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = btpl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = btpl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/btpl_datapath.sv
// Node memories, walk registers, free-node counter and response register.
`default_nettype none

module btpl_datapath #(
  parameter int unsigned NodeCount = btpl_pkg::NODE_COUNT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire btpl_pkg::cmd_t                cmd_i,
  output btpl_pkg::stat_t                    stat_o,
  input  wire logic                          req_type_i,
  input  wire logic [31:0]                   key_i,
  input  wire logic [31:0]                   prefix_mask_i,
  input  wire logic [btpl_pkg::HOP_W-1:0]    hop_address_i,
  input  wire logic [btpl_pkg::PORT_W-1:0]   port_in_i,
  output logic                               rsp_valid_o,
  input  wire logic                          rsp_ready_i,
  output logic [1:0]                         status_o,
  output logic [btpl_pkg::HOP_W-1:0]         hop_out_o,
  output logic [btpl_pkg::PORT_W-1:0]        port_out_o
);

  localparam int unsigned IdxW = $clog2(NodeCount);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned HopW = btpl_pkg::HOP_W;
  localparam int unsigned PortW = btpl_pkg::PORT_W;
  localparam int unsigned LvlW = btpl_pkg::LVL_W;

  // Node memories
  logic [IdxW-1:0]  c0_mem   [NodeCount];
  logic [IdxW-1:0]  c1_mem   [NodeCount];
  logic             rv_mem   [NodeCount];
  logic [HopW-1:0]  hop_mem  [NodeCount];
  logic [PortW-1:0] port_mem [NodeCount];

  // Walk state
  logic [IdxW-1:0]  cur_q;
  logic [LvlW-1:0]  lvl_q;
  logic [CntW-1:0]  nf_q;
  logic             lookup_q;
  logic [31:0]      key_q;
  logic [31:0]      mask_q;
  logic [HopW-1:0]  hop_q;
  logic [PortW-1:0] port_q;
  logic             full_q;
  logic             found_q;
  logic [HopW-1:0]  best_hop_q;
  logic [PortW-1:0] best_port_q;

  // Registered read data of the node at cur_q
  logic [IdxW-1:0]  rd_c0_q;
  logic [IdxW-1:0]  rd_c1_q;
  logic             rd_rv_q;
  logic [HopW-1:0]  rd_hop_q;
  logic [PortW-1:0] rd_port_q;

  // Response register
  logic                  out_valid_q;
  btpl_pkg::status_e     out_status_q;
  logic [HopW-1:0]       out_hop_q;
  logic [PortW-1:0]      out_port_q;

  logic [IdxW-1:0]  child_sel;
  logic             child_null;
  logic [CntW-1:0]  nf_inc;
  logic [IdxW-1:0]  new_idx;
  logic             chain_ok;
  logic             chain_link;
  logic [PortW-1:0] port_clamped;

  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             c0_we, c1_we, rv_we;
  logic [IdxW-1:0]  c0_wa, c1_wa, rv_wa;
  logic [IdxW-1:0]  c0_wd, c1_wd;

  // Child choice and pool checks
  assign child_sel  = key_q[0] ? rd_c1_q : rd_c0_q;
  assign child_null = (child_sel == '0) || (CntW'(child_sel) >= CntW'(NodeCount));
  assign nf_inc     = nf_q + CntW'(1);
  assign new_idx    = nf_q[IdxW-1:0];
  assign chain_ok   = nf_inc < CntW'(NodeCount);
  assign chain_link = mask_q[1] && chain_ok;

  assign port_clamped = (32'(port_q) >= 32'(btpl_pkg::PORT_COUNT)) ?
                        PortW'(btpl_pkg::PORT_COUNT - 1) : port_q;

  always_comb begin
    stat_o            = '0;
    stat_o.is_lookup  = lookup_q;
    stat_o.at_end     = lookup_q ? (lvl_q == LvlW'(btpl_pkg::KEY_BITS)) : !mask_q[0];
    stat_o.child_null = child_null;
    stat_o.pool_full  = nf_q >= CntW'(NodeCount);
    stat_o.chain_cont = mask_q[1];
    stat_o.chain_ok   = chain_ok;
    stat_o.out_free   = !out_valid_q || rsp_ready_i;
  end

  // Read port: root on accept, chosen child on a step
  assign rd_en   = cmd_i.accept || cmd_i.step;
  assign rd_addr = cmd_i.accept ? '0 : child_sel;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_c0_q   <= c0_mem[rd_addr];
      rd_c1_q   <= c1_mem[rd_addr];
      rd_rv_q   <= rv_mem[rd_addr];
      rd_hop_q  <= hop_mem[rd_addr];
      rd_port_q <= port_mem[rd_addr];
    end
  end

  // Child pointer write ports: root clear, parent link, fresh node init
  always_comb begin
    c0_we = cmd_i.init_root || (cmd_i.link && !key_q[0]) || cmd_i.alloc;
    c1_we = cmd_i.init_root || (cmd_i.link && key_q[0])  || cmd_i.alloc;
    c0_wa = cmd_i.init_root ? '0 : (cmd_i.link ? cur_q : new_idx);
    c1_wa = c0_wa;
    c0_wd = '0;
    c1_wd = '0;
    if (cmd_i.link) begin
      c0_wd = new_idx;
      c1_wd = new_idx;
    end else if (cmd_i.alloc && chain_link) begin
      // pre-link the fresh node to the one allocated next cycle
      if (key_q[1]) begin
        c1_wd = nf_inc[IdxW-1:0];
      end else begin
        c0_wd = nf_inc[IdxW-1:0];
      end
    end
  end

  assign rv_we = cmd_i.init_root || cmd_i.alloc || cmd_i.write_route;
  assign rv_wa = cmd_i.init_root ? '0 : (cmd_i.alloc ? new_idx : cur_q);

  always_ff @(posedge clk_i) begin
    if (c0_we) begin
      c0_mem[c0_wa] <= c0_wd;
    end
    if (c1_we) begin
      c1_mem[c1_wa] <= c1_wd;
    end
    if (rv_we) begin
      rv_mem[rv_wa] <= cmd_i.write_route;
    end
    if (cmd_i.write_route) begin
      hop_mem[cur_q]  <= hop_q;
      port_mem[cur_q] <= port_clamped;
    end
  end

  // Free-node counter and response handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q        <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.alloc) begin
        nf_q <= nf_inc;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lookup_q    <= (req_type_i == btpl_pkg::REQ_LOOKUP);
      key_q       <= key_i;
      mask_q      <= prefix_mask_i;
      hop_q       <= hop_address_i;
      port_q      <= port_in_i;
      cur_q       <= '0;
      lvl_q       <= '0;
      full_q      <= 1'b0;
      found_q     <= 1'b0;
      best_hop_q  <= '0;
      best_port_q <= '0;
    end else begin
      if (cmd_i.step || cmd_i.alloc) begin
        cur_q  <= cmd_i.alloc ? new_idx : child_sel;
        key_q  <= key_q >> 1;
        mask_q <= mask_q >> 1;
        lvl_q  <= lvl_q + LvlW'(1);
      end
      if (cmd_i.observe && rd_rv_q) begin
        found_q     <= 1'b1;
        best_hop_q  <= rd_hop_q;
        best_port_q <= rd_port_q;
      end
      if (cmd_i.set_full) begin
        full_q <= 1'b1;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (lookup_q) begin
        out_status_q <= found_q ? btpl_pkg::RSP_FOUND : btpl_pkg::RSP_NO_ROUTE;
        out_hop_q    <= best_hop_q;
        out_port_q   <= best_port_q;
      end else begin
        out_status_q <= full_q ? btpl_pkg::RSP_POOL_FULL : btpl_pkg::RSP_INSERTED;
        out_hop_q    <= '0;
        out_port_q   <= '0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign hop_out_o   = out_hop_q;
  assign port_out_o  = out_port_q;

endmodule

`default_nettype wire

### hw/rtl/binary_trie_prefix_lookup_unit.sv
// Top level of the binary trie longest-prefix lookup unit.
//
//  channel | dir | payload                                         | transfer
//  --------+-----+-------------------------------------------------+---------------------
//  req_i   | in  | req_type, key, prefix_mask, hop_address, port_in | valid && ready
//  rsp_o   | out | status, hop_out, port_out                        | valid && ready
//
// One request at a time. A lookup reads d nodes (1..33) from the root down,
// and each level costs one read of the node memory.
// An insert steps through the existing nodes, then allocates the new ones.
// After reset the S_INIT state clears the root entry; req_i.ready stays low meanwhile.
// A finished response sits in an output register; a stall on rsp_o holds only
// the next result, and the next request is taken while it waits.
`default_nettype none

module binary_trie_prefix_lookup_unit #(
  parameter int unsigned NodeCount = btpl_pkg::NODE_COUNT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  btpl_req_if.sink  req_i,
  btpl_rsp_if.source rsp_o
);

  btpl_pkg::cmd_t  cmd;
  btpl_pkg::stat_t stat;

  btpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  btpl_datapath #(
    .NodeCount (NodeCount)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_i.req_type),
    .key_i         (req_i.key),
    .prefix_mask_i (req_i.prefix_mask),
    .hop_address_i (req_i.hop_address),
    .port_in_i     (req_i.port_in),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .hop_out_o     (rsp_o.hop_out),
    .port_out_o    (rsp_o.port_out)
  );

endmodule

`default_nettype wire

### hw/rtl/btpl_checker.sv
// Port-level checks of the trie lookup unit and their bind to the top level.
`default_nettype none

module btpl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [1:0]  rsp_status_i,
  input wire logic [31:0] rsp_hop_i,
  input wire logic [1:0]  rsp_port_i
);

  // A stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_hop_i) && $stable(rsp_port_i))
    else $error("response payload changed while stalled");

  // Only a found route carries hop and port
  a_rsp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == btpl_pkg::RSP_INSERTED ||
                    rsp_status_i == btpl_pkg::RSP_NO_ROUTE ||
                    rsp_status_i == btpl_pkg::RSP_POOL_FULL)
      |-> rsp_hop_i == '0 && rsp_port_i == '0)
    else $error("hop or port set without a found route");

  // One request in work at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

endmodule

bind binary_trie_prefix_lookup_unit btpl_checker u_btpl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_hop_i    (rsp_o.hop_out),
  .rsp_port_i   (rsp_o.port_out)
);

`default_nettype wire
